// ===== rtl/core/max_window_sum_crop_top_defines.svh =====
`ifndef MAX_WINDOW_SUM_CROP_TOP_DEFINES_SVH
`define MAX_WINDOW_SUM_CROP_TOP_DEFINES_SVH

// same-cycle implication, off during reset
`define MSC_AST_IMPLY(lbl, clk, rst, a, c) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("implication check failed");

// next-cycle implication, off during reset
`define MSC_AST_NEXT(lbl, clk, rst, a, c) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("next-cycle check failed");

`endif

// ===== rtl/core/msc_pkg.sv =====
package msc_pkg;

   localparam int SUM_W   = 48;
   localparam int WIN_MAX = 64;

   localparam logic [1:0] CMD_LOAD = 2'd0;
   localparam logic [1:0] CMD_CROP = 2'd1;
   localparam logic [1:0] CMD_BEST = 2'd2;

   localparam logic [2:0] CSR_IMAGE_WIDTH   = 3'd0;
   localparam logic [2:0] CSR_IMAGE_HEIGHT  = 3'd1;
   localparam logic [2:0] CSR_IMAGE_DEPTH   = 3'd2;
   localparam logic [2:0] CSR_WINDOW_WIDTH  = 3'd3;
   localparam logic [2:0] CSR_WINDOW_HEIGHT = 3'd4;
   localparam logic [2:0] CSR_RESPONSE_MODE = 3'd5;

   localparam logic [1:0] MODE_IDENTITY = 2'd0;
   localparam logic [1:0] MODE_ABS      = 2'd1;
   localparam logic [1:0] MODE_SQUARE   = 2'd2;
   localparam logic [1:0] MODE_SSQUARE  = 2'd3;

   localparam logic signed [SUM_W-1:0] MOST_NEG = {1'b1, {(SUM_W-1){1'b0}}};

   typedef struct packed {
      logic we;
      logic re;
   } msc_mem_ctl_type;

endpackage

// ===== rtl/core/msc_xform.sv =====
module msc_xform (
   input  logic signed [15:0]             sample,
   input  logic [1:0]                     mode,
   output logic signed [msc_pkg::SUM_W-1:0] tf
);
   import msc_pkg::*;

   logic signed [31:0] sq;
   logic signed [SUM_W-1:0] lin;
   logic signed [SUM_W-1:0] mag;

   assign sq  = sample * sample;
   assign lin = SUM_W'(sample) <<< 8;
   assign mag = sample[15] ? -lin : lin;

   always_comb begin
      unique case (mode)
         MODE_IDENTITY: tf = lin;
         MODE_ABS:      tf = mag;
         MODE_SQUARE:   tf = SUM_W'(sq);
         MODE_SSQUARE:  tf = sample[15] ? -SUM_W'(sq) : SUM_W'(sq);
         default:       tf = lin;
      endcase
   end
endmodule

// ===== rtl/core/msc_mem.sv =====
module msc_mem #(
   parameter int AW = 14
) (
   input  logic                              clock,
   input  msc_pkg::msc_mem_ctl_type          ctl,
   input  logic [AW-1:0]                     addr,
   input  logic signed [msc_pkg::SUM_W-1:0]  wr_sum,
   input  logic signed [15:0]                wr_sample,
   output logic signed [msc_pkg::SUM_W-1:0]  rd_sum,
   output logic signed [15:0]                rd_sample
);
   import msc_pkg::*;

   localparam int DEPTH = 1 << AW;

   logic signed [SUM_W-1:0] sum_mem [DEPTH];
   logic signed [15:0]      smp_mem [DEPTH];

   always_ff @(posedge clock) begin
      if (ctl.we) begin
         sum_mem[addr] <= wr_sum;
         smp_mem[addr] <= wr_sample;
      end
      if (ctl.re) begin
         rd_sum    <= sum_mem[addr];
         rd_sample <= smp_mem[addr];
      end
   end
endmodule

// ===== rtl/core/max_window_sum_crop_top.sv =====
// channel | signals                                              | direction
// req     | req_valid req_ready req_cmd req_sample req_crop_*    | in
//         | req_channel                                          |
// rsp     | rsp_valid rsp_ready rsp_value rsp_best_* rsp_window_ | out
//         | sum rsp_image_ready rsp_fault                        |
// csr     | csr_we csr_index csr_data                            | in
// A load steps through the prefix memory's single port: up to six reads and one
// write in sequence, the last three reads only when the sample closes a window.
// Reads pass S_RQ (memory) and S_OUT (output register, may wait on rsp_ready).
// Reset is synchronous; it restores the state and CSR registers and clears the search.
// req_ready is low while an item is at work; a held result stalls only reads.
`include "max_window_sum_crop_top_defines.svh"

module max_window_sum_crop_top #(
   parameter int MAX_IMAGE_WIDTH  = 64,
   parameter int MAX_IMAGE_HEIGHT = 64,
   parameter int MAX_CHANNELS     = 4
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [1:0]                        req_cmd,
   input  logic signed [15:0]                req_sample,
   input  logic [5:0]                        req_crop_row,
   input  logic [5:0]                        req_crop_col,
   input  logic [1:0]                        req_channel,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [15:0]                rsp_value,
   output logic [5:0]                        rsp_best_row,
   output logic [5:0]                        rsp_best_col,
   output logic signed [msc_pkg::SUM_W-1:0]  rsp_window_sum,
   output logic                              rsp_image_ready,
   output logic                              rsp_fault,
   input  logic                              csr_we,
   input  logic [2:0]                        csr_index,
   input  logic [6:0]                        csr_data
);
   import msc_pkg::*;

   localparam int RB = (MAX_IMAGE_HEIGHT > 1) ? $clog2(MAX_IMAGE_HEIGHT) : 1;
   localparam int WB = (MAX_IMAGE_WIDTH > 1) ? $clog2(MAX_IMAGE_WIDTH) : 1;
   localparam int CB = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int AW = RB + WB + CB;
   localparam logic [8:0] MAXW9 = 9'(MAX_IMAGE_WIDTH);
   localparam logic [8:0] MAXH9 = 9'(MAX_IMAGE_HEIGHT);
   localparam logic [4:0] MAXC5 = 5'(MAX_CHANNELS);
   localparam logic [8:0] RST_W = (MAX_IMAGE_WIDTH < 64) ? MAXW9 : 9'd64;
   localparam logic [8:0] RST_H = (MAX_IMAGE_HEIGHT < 64) ? MAXH9 : 9'd64;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_LOAD = 2'd1;
   localparam logic [1:0] S_RQ   = 2'd2;
   localparam logic [1:0] S_OUT  = 2'd3;

   logic [1:0] state_ff, state_in;
   logic [3:0] step_ff, step_in;

   logic [8:0] img_w_ff, img_h_ff;
   logic [4:0] depth_ff;
   logic [6:0] win_w_ff, win_h_ff;
   logic [1:0] mode_ff;

   logic [RB-1:0] r_ff;
   logic [WB-1:0] c_ff;
   logic [CB-1:0] ch_ff;
   logic          complete_ff;

   logic signed [SUM_W-1:0] best_sum_ff [MAX_CHANNELS];
   logic [RB-1:0]           best_top_ff [MAX_CHANNELS];
   logic [WB-1:0]           best_left_ff [MAX_CHANNELS];

   logic signed [15:0]      smp_ff;
   logic signed [SUM_W-1:0] tf_ff, acc_ff, acc_in, opnd, tf;
   logic                    pend_ff, pend_neg_ff;

   logic [1:0] q_cmd_ff, q_ch_ff;
   logic [5:0] q_row_ff, q_col_ff;

   logic signed [15:0]      rsp_value_ff;
   logic [5:0]              rsp_row_ff, rsp_col_ff;
   logic signed [SUM_W-1:0] rsp_sum_ff;
   logic                    rsp_valid_ff, rsp_ready_flag_ff, rsp_fault_ff;

   msc_mem_ctl_type         mem_ctl;
   logic [AW-1:0]           mem_addr;
   logic signed [SUM_W-1:0] rd_sum;
   logic signed [15:0]      rd_sample;

   logic [8:0] r9, c9, rsel, csel, crop_r, crop_c;
   logic       rd_en, rd_neg, hit, fits, ch_bad, crop_bad, in_img, finish, restart;
   logic       acc_take, csr_hit;
   logic [CB-1:0] q_idx;
   logic [4:0] depth_next;
   logic [8:0] clamp_w, clamp_h;
   logic [6:0] clamp_ww, clamp_wh;

   msc_xform u_xform (
      .sample (req_sample),
      .mode   (mode_ff),
      .tf     (tf)
   );

   msc_mem #(.AW(AW)) u_mem (
      .clock     (clock),
      .ctl       (mem_ctl),
      .addr      (mem_addr),
      .wr_sum    (acc_in),
      .wr_sample (smp_ff),
      .rd_sum    (rd_sum),
      .rd_sample (rd_sample)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign acc_take  = req_valid && req_ready;

   assign r9   = 9'(r_ff);
   assign c9   = 9'(c_ff);
   assign hit  = (r9 + 9'd1 >= 9'(win_h_ff)) && (c9 + 9'd1 >= 9'(win_w_ff));
   assign fits = (9'(win_w_ff) <= img_w_ff) && (9'(win_h_ff) <= img_h_ff);

   always_comb begin
      rd_en  = 1'b0;
      rd_neg = 1'b0;
      rsel   = r9;
      csel   = c9;
      unique case (step_ff)
         4'd0: begin
            rd_en = (r9 != 9'd0);
            rsel  = r9 - 9'd1;
         end
         4'd1: begin
            rd_en = (c9 != 9'd0);
            csel  = c9 - 9'd1;
         end
         4'd2: begin
            rd_en  = (r9 != 9'd0) && (c9 != 9'd0);
            rd_neg = 1'b1;
            rsel   = r9 - 9'd1;
            csel   = c9 - 9'd1;
         end
         4'd5: begin
            rd_en  = (r9 >= 9'(win_h_ff));
            rd_neg = 1'b1;
            rsel   = r9 - 9'(win_h_ff);
         end
         4'd6: begin
            rd_en  = (c9 >= 9'(win_w_ff));
            rd_neg = 1'b1;
            csel   = c9 - 9'(win_w_ff);
         end
         4'd7: begin
            rd_en = (r9 >= 9'(win_h_ff)) && (c9 >= 9'(win_w_ff));
            rsel  = r9 - 9'(win_h_ff);
            csel  = c9 - 9'(win_w_ff);
         end
         default: begin
            rd_en = 1'b0;
         end
      endcase
   end

   assign q_idx    = CB'(q_ch_ff);
   assign crop_r   = 9'(best_top_ff[q_idx]) + 9'(q_row_ff);
   assign crop_c   = 9'(best_left_ff[q_idx]) + 9'(q_col_ff);
   assign in_img   = (crop_r < img_h_ff) && (crop_c < img_w_ff);
   assign ch_bad   = (5'(q_ch_ff) >= depth_ff);
   assign crop_bad = (7'(q_row_ff) >= win_h_ff) || (7'(q_col_ff) >= win_w_ff);

   always_comb begin
      mem_ctl.we = (state_ff == S_LOAD) && (step_ff == 4'd4);
      mem_ctl.re = ((state_ff == S_LOAD) && rd_en) || (state_ff == S_RQ);
      if (state_ff == S_RQ) begin
         mem_addr = {ch_ff, RB'(crop_r), WB'(crop_c)};
         mem_addr[AW-1 -: CB] = q_idx;
      end else begin
         mem_addr = {ch_ff, RB'(rsel), WB'(csel)};
      end
   end

   always_comb begin
      if (step_ff == 4'd4) begin
         opnd = tf_ff;
      end else if (pend_ff) begin
         opnd = pend_neg_ff ? -rd_sum : rd_sum;
      end else begin
         opnd = '0;
      end
      acc_in = acc_ff + opnd;
   end

   assign finish = (state_ff == S_LOAD) &&
                   (((step_ff == 4'd4) && !hit) || (step_ff == 4'd9));

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      unique case (state_ff)
         S_IDLE: begin
            step_in = 4'd0;
            if (acc_take) begin
               priority if (req_cmd == CMD_LOAD) begin
                  state_in = S_LOAD;
               end else if (req_cmd == CMD_CROP || req_cmd == CMD_BEST) begin
                  state_in = S_RQ;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_LOAD: begin
            step_in = step_ff + 4'd1;
            if (finish) begin
               state_in = S_IDLE;
            end
         end
         S_RQ: begin
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      clamp_w = 9'(csr_data);
      if (clamp_w == 9'd0) clamp_w = 9'd1;
      if (clamp_w > MAXW9) clamp_w = MAXW9;
      clamp_h = 9'(csr_data);
      if (clamp_h == 9'd0) clamp_h = 9'd1;
      if (clamp_h > MAXH9) clamp_h = MAXH9;
      depth_next = 5'(csr_data[2:0]);
      if (depth_next == 5'd0) depth_next = 5'd1;
      if (depth_next > MAXC5) depth_next = MAXC5;
      clamp_ww = (csr_data == 7'd0) ? 7'd1 : csr_data;
      if (clamp_ww > 7'(WIN_MAX)) clamp_ww = 7'(WIN_MAX);
      clamp_wh = clamp_ww;
   end

   assign csr_hit = csr_we && (csr_index <= CSR_RESPONSE_MODE);
   assign restart = csr_hit || (acc_take && (req_cmd == CMD_LOAD) && complete_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         step_ff     <= 4'd0;
         img_w_ff    <= RST_W;
         img_h_ff    <= RST_H;
         depth_ff    <= 5'd1;
         win_w_ff    <= 7'd8;
         win_h_ff    <= 7'd8;
         mode_ff     <= MODE_IDENTITY;
         r_ff        <= '0;
         c_ff        <= '0;
         ch_ff       <= '0;
         complete_ff <= 1'b0;
         pend_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < MAX_CHANNELS; i++) begin
            best_sum_ff[i]  <= MOST_NEG;
            best_top_ff[i]  <= '0;
            best_left_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         pend_ff  <= (state_ff == S_LOAD) && rd_en;
         if (csr_we) begin
            unique case (csr_index)
               CSR_IMAGE_WIDTH:   img_w_ff <= clamp_w;
               CSR_IMAGE_HEIGHT:  img_h_ff <= clamp_h;
               CSR_IMAGE_DEPTH:   depth_ff <= depth_next;
               CSR_WINDOW_WIDTH:  win_w_ff <= clamp_ww;
               CSR_WINDOW_HEIGHT: win_h_ff <= clamp_wh;
               CSR_RESPONSE_MODE: mode_ff  <= csr_data[1:0];
               default: begin
               end
            endcase
         end
         if (restart) begin
            r_ff        <= '0;
            c_ff        <= '0;
            ch_ff       <= '0;
            complete_ff <= 1'b0;
            for (int i = 0; i < MAX_CHANNELS; i++) begin
               best_sum_ff[i]  <= MOST_NEG;
               best_top_ff[i]  <= '0;
               best_left_ff[i] <= '0;
            end
         end
         if ((state_ff == S_LOAD) && (step_ff == 4'd9) && (acc_ff > best_sum_ff[ch_ff])) begin
            best_sum_ff[ch_ff]  <= acc_ff;
            best_top_ff[ch_ff]  <= RB'(r9 + 9'd1 - 9'(win_h_ff));
            best_left_ff[ch_ff] <= WB'(c9 + 9'd1 - 9'(win_w_ff));
         end
         if (finish) begin
            if (5'(ch_ff) + 5'd1 < depth_ff) begin
               ch_ff <= ch_ff + CB'(1);
            end else begin
               ch_ff <= '0;
               if (c9 + 9'd1 < img_w_ff) begin
                  c_ff <= c_ff + WB'(1);
               end else begin
                  c_ff <= '0;
                  if (r9 + 9'd1 < img_h_ff) begin
                     r_ff <= r_ff + RB'(1);
                  end else begin
                     r_ff        <= '0;
                     complete_ff <= 1'b1;
                  end
               end
            end
         end
         if ((state_ff == S_OUT) && (!rsp_valid_ff || rsp_ready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      pend_neg_ff <= rd_neg;
      if (acc_take) begin
         smp_ff   <= req_sample;
         tf_ff    <= tf;
         acc_ff   <= '0;
         q_cmd_ff <= req_cmd;
         q_ch_ff  <= req_channel;
         q_row_ff <= req_crop_row;
         q_col_ff <= req_crop_col;
      end else if (state_ff == S_LOAD) begin
         acc_ff <= acc_in;
      end
      if ((state_ff == S_OUT) && (!rsp_valid_ff || rsp_ready)) begin
         rsp_ready_flag_ff <= complete_ff;
         if (ch_bad) begin
            rsp_value_ff <= '0;
            rsp_row_ff   <= '0;
            rsp_col_ff   <= '0;
            rsp_sum_ff   <= '0;
            rsp_fault_ff <= 1'b1;
         end else begin
            rsp_row_ff <= 6'(best_top_ff[q_idx]);
            rsp_col_ff <= 6'(best_left_ff[q_idx]);
            rsp_sum_ff <= best_sum_ff[q_idx];
            if ((q_cmd_ff == CMD_CROP) && !crop_bad && fits && complete_ff && in_img) begin
               rsp_value_ff <= rd_sample;
            end else begin
               rsp_value_ff <= '0;
            end
            rsp_fault_ff <= !fits || ((q_cmd_ff == CMD_CROP) && crop_bad);
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_value       = rsp_value_ff;
   assign rsp_best_row    = rsp_row_ff;
   assign rsp_best_col    = rsp_col_ff;
   assign rsp_window_sum  = rsp_sum_ff;
   assign rsp_image_ready = rsp_ready_flag_ff;
   assign rsp_fault       = rsp_fault_ff;

   `MSC_AST_IMPLY(a_done_at_origin, clock, reset, complete_ff, (r_ff == '0) && (c_ff == '0) && (ch_ff == '0))
   `MSC_AST_IMPLY(a_ch_in_depth, clock, reset, 1'b1, 5'(ch_ff) < depth_ff)
   `MSC_AST_IMPLY(a_value_needs_image, clock, reset, rsp_valid_ff && (rsp_value_ff != '0), rsp_ready_flag_ff)
   `MSC_AST_NEXT(a_load_busy, clock, reset, acc_take && (req_cmd == CMD_LOAD), !req_ready)

endmodule

// ===== verif/max_window_sum_crop_top_tb.sv =====
`timescale 1ns / 100ps

module max_window_sum_crop_top_tb;
   import msc_pkg::*;

   localparam logic [1:0] CMD_NONE = 2'd3;
   localparam int STORE_SIZE = 16384;
   localparam int IDLE_PCT = 21;
   localparam int HOLD_CYCLES = 400;
   localparam int WATCHDOG_LIMIT = 5000;

   typedef struct {
      logic [1:0]         cmd;
      logic signed [15:0] sample;
      logic [5:0]         crop_row;
      logic [5:0]         crop_col;
      logic [1:0]         channel;
   } req_item_type;

   typedef struct {
      logic signed [15:0] value;
      logic [5:0]         best_row;
      logic [5:0]         best_col;
      logic [47:0]        window_sum;
      logic               image_ready;
      logic               fault;
   } rsp_item_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [1:0] req_cmd = CMD_LOAD;
   logic signed [15:0] req_sample = '0;
   logic [5:0] req_crop_row = '0;
   logic [5:0] req_crop_col = '0;
   logic [1:0] req_channel = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [15:0] rsp_value;
   logic [5:0] rsp_best_row;
   logic [5:0] rsp_best_col;
   logic signed [SUM_W-1:0] rsp_window_sum;
   logic rsp_image_ready;
   logic rsp_fault;
   logic csr_we = 1'b0;
   logic [2:0] csr_index = '0;
   logic [6:0] csr_data = '0;

   req_item_type pending_items[$];
   rsp_item_type expected_rsps[$];
   int errors = 0;
   int rsp_count = 0;
   int hold_left = 0;
   bit hold_done = 0;
   bit quiet = 0;
   int stall_cycles = 0;

   // predictor state
   int img_w, img_h, img_d, win_w, win_h;
   logic [1:0] mode;
   logic signed [15:0] sample_mem[STORE_SIZE];
   longint prefix_mem[STORE_SIZE];
   longint best_sum[4];
   int best_top[4];
   int best_left[4];
   int load_pos;
   bit complete;

   max_window_sum_crop_top i_dut (.*);

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic int clamp_val(int v, int hi);
      if (v == 0) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic void clear_search();
      for (int i = 0; i < 4; i++) begin
         best_sum[i] = -longint'(48'h800000000000);
         best_top[i] = 0;
         best_left[i] = 0;
      end
      load_pos = 0;
      complete = 0;
   endfunction

   function automatic int pix_addr(int r, int c, int ch);
      return (r * img_w + c) * img_d + ch;
   endfunction

   function automatic longint shape_sample(int s);
      longint sq;
      sq = longint'(s) * longint'(s);
      case (mode)
         MODE_ABS: return (s < 0 ? -longint'(s) : longint'(s)) * 256;
         MODE_SQUARE: return sq;
         MODE_SSQUARE: return s < 0 ? -sq : sq;
         default: return longint'(s) * 256;
      endcase
   endfunction

   function automatic void accumulate_sample(int s);
      int total, pos, ch, pix, r, c, here;
      longint up, lf, dg, d, b, l, a, sum;
      total = img_w * img_h * img_d;
      if (complete) clear_search();
      pos = load_pos;
      if (pos >= total) pos = 0;
      ch = pos % img_d;
      pix = pos / img_d;
      c = pix % img_w;
      r = pix / img_w;
      here = pix_addr(r, c, ch);
      up = r > 0 ? prefix_mem[pix_addr(r - 1, c, ch)] : 0;
      lf = c > 0 ? prefix_mem[pix_addr(r, c - 1, ch)] : 0;
      dg = (r > 0 && c > 0) ? prefix_mem[pix_addr(r - 1, c - 1, ch)] : 0;
      sample_mem[here] = 16'(s);
      prefix_mem[here] = up + lf + shape_sample(s) - dg;
      if (r + 1 >= win_h && c + 1 >= win_w) begin
         d = prefix_mem[here];
         b = r >= win_h ? prefix_mem[pix_addr(r - win_h, c, ch)] : 0;
         l = c >= win_w ? prefix_mem[pix_addr(r, c - win_w, ch)] : 0;
         a = (r >= win_h && c >= win_w) ?
             prefix_mem[pix_addr(r - win_h, c - win_w, ch)] : 0;
         sum = a + d - b - l;
         if (sum > best_sum[ch]) begin
            best_sum[ch] = sum;
            best_top[ch] = r + 1 - win_h;
            best_left[ch] = c + 1 - win_w;
         end
      end
      pos++;
      if (pos >= total) begin
         pos = 0;
         complete = 1;
      end
      load_pos = pos;
   endfunction

   function automatic void predict_item(req_item_type it);
      rsp_item_type e;
      bit flt;
      int r, c;
      if (it.cmd == CMD_LOAD) begin
         accumulate_sample(it.sample);
         return;
      end
      if (it.cmd == CMD_NONE) return;
      flt = !(win_w <= img_w && win_h <= img_h);
      e = '{0, 0, 0, 0, complete, 0};
      if (it.channel >= img_d) begin
         e.fault = 1;
         expected_rsps.push_back(e);
         return;
      end
      e.best_row = 6'(best_top[it.channel]);
      e.best_col = 6'(best_left[it.channel]);
      e.window_sum = best_sum[it.channel][47:0];
      if (it.cmd == CMD_CROP) begin
         if (it.crop_row >= win_h || it.crop_col >= win_w) begin
            flt = 1;
         end else if (!flt && complete) begin
            r = best_top[it.channel] + it.crop_row;
            c = best_left[it.channel] + it.crop_col;
            if (r < img_h && c < img_w) e.value = sample_mem[pix_addr(r, c, it.channel)];
         end
      end
      e.fault = flt;
      expected_rsps.push_back(e);
   endfunction

   // sender
   always @(posedge clock) begin
      req_item_type it;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            predict_item('{req_cmd, req_sample, req_crop_row, req_crop_col, req_channel});
         end
         if (!req_valid || req_ready) begin
            if (pending_items.size() > 0 && (quiet || $urandom_range(0, 99) >= IDLE_PCT)) begin
               it = pending_items.pop_front();
               req_valid <= 1'b1;
               req_cmd <= it.cmd;
               req_sample <= it.sample;
               req_crop_row <= it.crop_row;
               req_crop_col <= it.crop_col;
               req_channel <= it.channel;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver, with one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (!hold_done && rsp_count == 100) begin
         hold_left <= HOLD_CYCLES;
         hold_done <= 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= quiet || $urandom_range(0, 99) >= IDLE_PCT;
      end
   end

   always @(posedge clock) begin
      rsp_item_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         rsp_count <= rsp_count + 1;
         if (expected_rsps.size() == 0) begin
            $display("%0t: unexpected result value=%0d row=%0d col=%0d sum=%0h",
                     $time, rsp_value, rsp_best_row, rsp_best_col, rsp_window_sum);
            errors++;
         end else begin
            e = expected_rsps.pop_front();
            if (rsp_value !== e.value) begin
               $display("%0t: value exp %0d got %0d", $time, e.value, rsp_value);
               errors++;
            end
            if (rsp_best_row !== e.best_row) begin
               $display("%0t: best_row exp %0d got %0d", $time, e.best_row, rsp_best_row);
               errors++;
            end
            if (rsp_best_col !== e.best_col) begin
               $display("%0t: best_col exp %0d got %0d", $time, e.best_col, rsp_best_col);
               errors++;
            end
            if (rsp_window_sum !== e.window_sum) begin
               $display("%0t: window_sum exp %0h got %0h", $time, e.window_sum,
                        rsp_window_sum);
               errors++;
            end
            if (rsp_image_ready !== e.image_ready) begin
               $display("%0t: image_ready exp %0b got %0b", $time, e.image_ready,
                        rsp_image_ready);
               errors++;
            end
            if (rsp_fault !== e.fault) begin
               $display("%0t: fault exp %0b got %0b", $time, e.fault, rsp_fault);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   task automatic drain();
      do begin
         @(posedge clock);
         #1;
      end while (pending_items.size() > 0 || req_valid || expected_rsps.size() > 0);
      repeat (30) @(posedge clock);
   endtask

   task automatic write_csr(logic [2:0] idx, logic [6:0] data);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      case (idx)
         CSR_IMAGE_WIDTH: img_w = clamp_val(data, 64);
         CSR_IMAGE_HEIGHT: img_h = clamp_val(data, 64);
         CSR_IMAGE_DEPTH: img_d = clamp_val(data[2:0], 4);
         CSR_WINDOW_WIDTH: win_w = clamp_val(data, WIN_MAX);
         CSR_WINDOW_HEIGHT: win_h = clamp_val(data, WIN_MAX);
         CSR_RESPONSE_MODE: mode = data[1:0];
         default: ;
      endcase
      clear_search();
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic setup(int w, int h, int d, int ww, int wh, int m);
      drain();
      write_csr(CSR_IMAGE_WIDTH, 7'(w));
      write_csr(CSR_IMAGE_HEIGHT, 7'(h));
      write_csr(CSR_IMAGE_DEPTH, 7'(d));
      write_csr(CSR_WINDOW_WIDTH, 7'(ww));
      write_csr(CSR_WINDOW_HEIGHT, 7'(wh));
      write_csr(CSR_RESPONSE_MODE, 7'(m));
   endtask

   function automatic logic signed [15:0] pick_sample();
      case ($urandom_range(0, 9))
         0: return 16'sh7fff;
         1: return 16'sh8000;
         2: return 16'sh0000;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic void add_read(logic [1:0] cmd, bit wild);
      req_item_type it;
      it.cmd = cmd;
      it.sample = 16'($urandom);
      it.channel = 2'($urandom_range(0, 3));
      if (wild) begin
         it.crop_row = 6'($urandom);
         it.crop_col = 6'($urandom);
      end else begin
         it.crop_row = 6'($urandom_range(0, win_h - 1));
         it.crop_col = 6'($urandom_range(0, win_w - 1));
      end
      pending_items.push_back(it);
   endfunction

   function automatic void add_image(int loads);
      req_item_type it;
      for (int i = 0; i < loads; i++) begin
         it = '{CMD_LOAD, pick_sample(), 6'($urandom), 6'($urandom), 2'($urandom)};
         pending_items.push_back(it);
         if ($urandom_range(0, 99) < 8) add_read(2'($urandom_range(1, 2)), 1'b1);
         if ($urandom_range(0, 99) < 2) begin
            it.cmd = CMD_NONE;
            pending_items.push_back(it);
         end
      end
   endfunction

   initial begin
      int sent, w, h, d, phase;
      img_w = 64; img_h = 64; img_d = 1; win_w = 8; win_h = 8;
      mode = MODE_IDENTITY;
      clear_search();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      pending_items.push_back('{CMD_BEST, 0, 0, 0, 0});
      pending_items.push_back('{CMD_CROP, 0, 63, 63, 0});
      pending_items.push_back('{CMD_CROP, 0, 1, 1, 0});
      pending_items.push_back('{CMD_BEST, 0, 0, 0, 3});
      pending_items.push_back('{CMD_NONE, 16'sh7fff, 63, 63, 3});
      setup(2, 2, 7, 127, 0, MODE_SSQUARE);
      add_image(16);
      add_read(CMD_BEST, 1'b0);
      add_read(CMD_CROP, 1'b0);
      setup(2, 2, 2, 1, 1, MODE_ABS);
      for (int i = 0; i < 8; i++) begin
         pending_items.push_back('{CMD_LOAD, (i % 2) ? 16'sh8000 : 16'sh7fff, 0, 0, 0});
      end
      pending_items.push_back('{CMD_CROP, 0, 0, 0, 1});
      pending_items.push_back('{CMD_BEST, 0, 0, 0, 0});
      pending_items.push_back('{CMD_CROP, 0, 0, 1, 0});

      setup(64, 2, 1, 64, 2, MODE_SQUARE);
      add_image(128);
      for (int i = 0; i < 6; i++) add_read(CMD_CROP, 1'b0);
      setup(2, 64, 1, 1, 64, MODE_IDENTITY);
      add_image(128);
      for (int i = 0; i < 6; i++) add_read(CMD_CROP, 1'b0);

      sent = 0;
      phase = 0;
      while (sent < 1350) begin
         w = $urandom_range(0, 8);
         h = $urandom_range(0, 8);
         d = $urandom_range(0, 9) == 0 ? 7 : $urandom_range(1, 4);
         setup(w, h, d, $urandom_range(0, 9) == 0 ? 127 : $urandom_range(0, w + 1),
               $urandom_range(0, h + 1), $urandom_range(0, 3));
         quiet = (phase == 5);
         for (int k = 0; k < 2; k++) begin
            add_image(img_w * img_h * img_d);
            for (int i = 0; i < 10; i++) begin
               add_read(2'($urandom_range(1, 2)), $urandom_range(0, 4) == 0);
            end
            sent += img_w * img_h * img_d + 10;
         end
         add_image($urandom_range(0, 5));
         add_read(CMD_CROP, 1'b0);
         phase++;
      end
      drain();
      if (errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/msc_pkg.sv
rtl/core/msc_xform.sv
rtl/core/msc_mem.sv
rtl/core/max_window_sum_crop_top.sv
verif/max_window_sum_crop_top_tb.sv
